// ===== rtl/core/rrtf_pkg.sv =====
// rrtf_pkg: shared types, constants and status codes for the range rule table filter
// no dependencies
`timescale 1ns / 1ps
package rrtf_pkg;
	localparam int RULE_DEPTH = 128;
	localparam int LOG_LIMIT = 128;
	localparam int SLOT_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
	localparam int CNT_W = $clog2(RULE_DEPTH + 1);
	localparam int HIT_W = 8;
	localparam int RULE_W = 96;
	localparam int ENT_W = RULE_W + HIT_W;
	localparam int QDEPTH = 2;

	localparam logic [1:0] REQ_ADD = 2'd0;
	localparam logic [1:0] REQ_DEL = 2'd1;
	localparam logic [1:0] REQ_CHK = 2'd2;
	localparam logic [1:0] REQ_UNK = 2'd3;

	localparam logic [2:0] ST_ADDED = 3'd0;
	localparam logic [2:0] ST_FULL = 3'd1;
	localparam logic [2:0] ST_INVALID = 3'd2;
	localparam logic [2:0] ST_DELETED = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_ACCEPTED = 3'd5;
	localparam logic [2:0] ST_REJECTED = 3'd6;

	// classified request passed from front to back
	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] lo_a;
		logic [31:0] hi_a;
		logic [15:0] lo_p;
		logic [15:0] hi_p;
		logic [31:0] pa;
		logic [15:0] pp;
	} req_t;
endpackage

// ===== rtl/core/rrtf_ram.sv =====
// rrtf_ram: generic single write, single read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module rrtf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/rrtf_front.sv =====
// rrtf_front: input transaction acceptance and request queue
// depends on rrtf_pkg
`timescale 1ns / 1ps
module rrtf_front import rrtf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input req_t in_req,
	output logic q_valid,
	input logic q_ready,
	output req_t q_req
);
	req_t buf_q [QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_req = buf_q[rp_q];

	// payload storage
	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= in_req;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== rtl/core/rrtf_back.sv =====
// rrtf_back: rule table sequencer for add, delete with compaction, and first-match check
// depends on rrtf_pkg and rrtf_ram
`timescale 1ns / 1ps
module rrtf_back import rrtf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input req_t q_req,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] status,
	output logic [6:0] rule_slot,
	output logic [7:0] hit_total,
	output logic busy
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_CMP = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_OUT = 3'd4;

	logic [2:0] state_q;
	req_t req_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [SLOT_W-1:0] raddr;
	logic [ENT_W-1:0] rdata;
	logic we;
	logic [SLOT_W-1:0] waddr;
	logic [ENT_W-1:0] wdata;
	logic [2:0] st_q;
	logic [6:0] slot_q;
	logic [7:0] hit_q;
	logic [31:0] e_lo_a, e_hi_a;
	logic [15:0] e_lo_p, e_hi_p;
	logic [HIT_W-1:0] e_hit, hit_inc;
	logic del_hit, chk_hit;
	logic [CNT_W-1:0] idx_nx;
	logic [CNT_W-1:0] idx_pv;

	rrtf_ram #(.WIDTH(ENT_W), .DEPTH(RULE_DEPTH)) u_tab (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign {e_lo_a, e_hi_a, e_lo_p, e_hi_p, e_hit} = rdata;
	assign del_hit = (e_lo_a == req_q.lo_a) && (e_hi_a == req_q.hi_a) &&
		(e_lo_p == req_q.lo_p) && (e_hi_p == req_q.hi_p);
	assign chk_hit = (req_q.pa >= e_lo_a) && (req_q.pa <= e_hi_a) &&
		(req_q.pp >= e_lo_p) && (req_q.pp <= e_hi_p);
	assign hit_inc = (e_hit < HIT_W'(LOG_LIMIT)) ? e_hit + 1'b1 : HIT_W'(LOG_LIMIT);
	assign idx_nx = idx_q + 1'b1;
	assign idx_pv = idx_q - 1'b1;

	assign q_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status = st_q;
	assign rule_slot = slot_q;
	assign hit_total = hit_q;
	assign busy = (state_q != S_IDLE);

	// read address: slot idx while scanning, next slot while comparing or shifting
	always_comb begin
		raddr = idx_q[SLOT_W-1:0];
		if (state_q == S_SHIFT || state_q == S_CMP) raddr = idx_nx[SLOT_W-1:0];
	end

	// table write: add, check count update, delete move-down
	always_comb begin
		we = 1'b0;
		waddr = idx_q[SLOT_W-1:0];
		wdata = rdata;
		if (state_q == S_IDLE && q_valid && q_req.kind == REQ_ADD &&
				count_q < CNT_W'(RULE_DEPTH) && q_req.lo_p <= q_req.hi_p) begin
			we = 1'b1;
			waddr = count_q[SLOT_W-1:0];
			wdata = {q_req.lo_a, q_req.hi_a, q_req.lo_p, q_req.hi_p, HIT_W'(0)};
		end else if (state_q == S_CMP && req_q.kind == REQ_CHK && chk_hit) begin
			we = 1'b1;
			wdata = {e_lo_a, e_hi_a, e_lo_p, e_hi_p, hit_inc};
		end else if (state_q == S_SHIFT && idx_q != count_q) begin
			we = 1'b1;
			waddr = idx_pv[SLOT_W-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						idx_q <= '0;
						if (q_req.kind == REQ_ADD) begin
							state_q <= S_OUT;
							if (count_q < CNT_W'(RULE_DEPTH) && q_req.lo_p <= q_req.hi_p)
								count_q <= count_q + 1'b1;
						end else if ((q_req.kind == REQ_DEL || q_req.kind == REQ_CHK) &&
								count_q != '0) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_SCAN: state_q <= S_CMP;
				S_CMP: begin
					if (req_q.kind == REQ_DEL && del_hit) begin
						idx_q <= idx_nx;
						state_q <= S_SHIFT;
					end else if (req_q.kind == REQ_CHK && chk_hit) begin
						state_q <= S_OUT;
					end else if (idx_nx == count_q) begin
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_nx;
						state_q <= S_SCAN;
					end
				end
				S_SHIFT: begin
					// idx points at the source slot whose data is in rdata
					if (idx_q == count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_nx;
					end
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request capture and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_valid) begin
			req_q <= q_req;
			slot_q <= '0;
			hit_q <= '0;
			case (q_req.kind)
				REQ_ADD: begin
					if (count_q >= CNT_W'(RULE_DEPTH)) st_q <= ST_FULL;
					else if (q_req.lo_p > q_req.hi_p) st_q <= ST_INVALID;
					else begin
						st_q <= ST_ADDED;
						slot_q <= 7'(count_q);
					end
				end
				REQ_DEL: st_q <= ST_NOT_FOUND;
				default: st_q <= ST_REJECTED;
			endcase
		end else if (state_q == S_CMP) begin
			if (req_q.kind == REQ_DEL && del_hit) begin
				st_q <= ST_DELETED;
				slot_q <= 7'(idx_q);
			end else if (req_q.kind == REQ_CHK && chk_hit) begin
				st_q <= ST_ACCEPTED;
				slot_q <= 7'(idx_q);
				hit_q <= hit_inc;
			end
		end
	end
endmodule

// ===== rtl/core/range_rule_table_filter.sv =====
// range_rule_table_filter: top level, request queue in front of the rule table sequencer
// depends on rrtf_pkg, rrtf_front, rrtf_back
//
// channel | signals                          | direction
// in      | in_valid, in_ready, request flds | into block
// out     | out_valid, out_ready, result flds| out of block
//
// add writes the table straight from idle; check and delete scan one rule at a time
// (ram read, then compare), delete then moves each later rule down one slot per cycle.
// the scan is serial, set by the single table ram port pair.
// reset clears the rule count and sequencer state; the table ram holds no reset value.
// a two entry queue accepts requests while the sequencer works or the result stalls.
`timescale 1ns / 1ps
module range_rule_table_filter import rrtf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] req_type,
	input logic [31:0] range_start_addr,
	input logic [31:0] range_end_addr,
	input logic [15:0] range_start_port,
	input logic [15:0] range_end_port,
	input logic [31:0] probe_addr,
	input logic [15:0] probe_port,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] status,
	output logic [6:0] rule_slot,
	output logic [7:0] hit_total
);
	req_t in_req, q_req;
	logic q_valid, q_ready, busy;

	assign in_req = '{kind: req_type, lo_a: range_start_addr, hi_a: range_end_addr,
		lo_p: range_start_port, hi_p: range_end_port, pa: probe_addr, pp: probe_port};

	rrtf_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	rrtf_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.rule_slot(rule_slot), .hit_total(hit_total), .busy(busy)
	);

`ifndef NO_ASSERTIONS
	// the sequencer takes a queued transaction only when idle
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |-> !busy) else $error("take while busy");
	// shown results carry zero hit count unless status is accepted
	a_hits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_ACCEPTED) |-> (hit_total == 8'd0))
		else $error("hit count on non-match");
	// a result shown is not withdrawn before it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif
endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for range_rule_table_filter, first-match rule table
// depends on rrtf_pkg and the range_rule_table_filter rtl
`timescale 1ns / 1ps

// shadow rule table and queue of expected responses
class rule_scoreboard;
	logic [31:0] lo_a[$];
	logic [31:0] hi_a[$];
	logic [15:0] lo_p[$];
	logic [15:0] hi_p[$];
	logic [7:0] hits[$];
	logic [2:0] want_status[$];
	logic [6:0] want_slot[$];
	logic [7:0] want_hits[$];
	int errors;
	int compared;

	function void push_result(logic [2:0] s, int slot, logic [7:0] h);
		want_status.push_back(s);
		want_slot.push_back(slot[6:0]);
		want_hits.push_back(h);
	endfunction

	// apply one accepted request to the shadow table
	function void note_request(logic [1:0] kind, logic [31:0] sa, logic [31:0] ea,
		logic [15:0] sp, logic [15:0] ep, logic [31:0] pa, logic [15:0] pp);
		int n;
		bit found;
		n = lo_a.size();
		found = 0;
		if (kind == rrtf_pkg::REQ_ADD) begin
			if (n >= rrtf_pkg::RULE_DEPTH)
				push_result(rrtf_pkg::ST_FULL, 0, 0);
			else if (sp > ep)
				push_result(rrtf_pkg::ST_INVALID, 0, 0);
			else begin
				lo_a.push_back(sa); hi_a.push_back(ea);
				lo_p.push_back(sp); hi_p.push_back(ep); hits.push_back(0);
				push_result(rrtf_pkg::ST_ADDED, n, 0);
			end
		end else if (kind == rrtf_pkg::REQ_DEL) begin
			for (int i = 0; i < n && !found; i++) begin
				if (lo_a[i] == sa && hi_a[i] == ea && lo_p[i] == sp && hi_p[i] == ep) begin
					found = 1;
					lo_a.delete(i); hi_a.delete(i); lo_p.delete(i);
					hi_p.delete(i); hits.delete(i);
					push_result(rrtf_pkg::ST_DELETED, i, 0);
				end
			end
			if (!found)
				push_result(rrtf_pkg::ST_NOT_FOUND, 0, 0);
		end else if (kind == rrtf_pkg::REQ_CHK) begin
			for (int i = 0; i < n && !found; i++) begin
				if (pa >= lo_a[i] && pa <= hi_a[i] && pp >= lo_p[i] && pp <= hi_p[i]) begin
					found = 1;
					if (hits[i] < rrtf_pkg::LOG_LIMIT)
						hits[i] = hits[i] + 1;
					push_result(rrtf_pkg::ST_ACCEPTED, i, hits[i]);
				end
			end
			if (!found)
				push_result(rrtf_pkg::ST_REJECTED, 0, 0);
		end else begin
			push_result(rrtf_pkg::ST_REJECTED, 0, 0);
		end
	endfunction

	// compare one response with the oldest expectation
	function void check_result(logic [2:0] s, logic [6:0] slot, logic [7:0] h);
		logic [2:0] es;
		logic [6:0] eslot;
		logic [7:0] eh;
		if (want_status.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected response status=%0d slot=%0d hits=%0d", s, slot, h);
			return;
		end
		es = want_status.pop_front();
		eslot = want_slot.pop_front();
		eh = want_hits.pop_front();
		compared++;
		if (s !== es || slot !== eslot || h !== eh) begin
			errors++;
			if (errors <= 10)
				$display("mismatch #%0d: expected status=%0d slot=%0d hits=%0d, got %0d %0d %0d",
					compared, es, eslot, eh, s, slot, h);
		end
	endfunction
endclass

module tb;
	import rrtf_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] req_type = 0;
	logic [31:0] range_start_addr = 0;
	logic [31:0] range_end_addr = 0;
	logic [15:0] range_start_port = 0;
	logic [15:0] range_end_port = 0;
	logic [31:0] probe_addr = 0;
	logic [15:0] probe_port = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [2:0] status;
	logic [6:0] rule_slot;
	logic [7:0] hit_total;

	rule_scoreboard sb = new();
	bit quiet_tail = 0;
	bit send_done = 0;

	// pool of rules known to the bench, reused for deletes and probes
	logic [31:0] pool_sa[$];
	logic [31:0] pool_ea[$];
	logic [15:0] pool_sp[$];
	logic [15:0] pool_ep[$];

	range_rule_table_filter DUT (.*);

	always #2 clk = ~clk;

	// send one request and wait for its acceptance
	task automatic send_request(logic [1:0] kind, logic [31:0] sa, logic [31:0] ea,
		logic [15:0] sp, logic [15:0] ep, logic [31:0] pa, logic [15:0] pp);
		int gap;
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		req_type <= kind;
		range_start_addr <= sa;
		range_end_addr <= ea;
		range_start_port <= sp;
		range_end_port <= ep;
		probe_addr <= pa;
		probe_port <= pp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(kind, sa, ea, sp, ep, pa, pp);
		if (kind == REQ_ADD && sp <= ep) begin
			pool_sa.push_back(sa); pool_ea.push_back(ea);
			pool_sp.push_back(sp); pool_ep.push_back(ep);
		end
	endtask

	task automatic send_add(logic [31:0] sa, logic [31:0] ea, logic [15:0] sp, logic [15:0] ep);
		send_request(REQ_ADD, sa, ea, sp, ep, $urandom, 16'($urandom));
	endtask

	task automatic send_check(logic [31:0] pa, logic [15:0] pp);
		send_request(REQ_CHK, $urandom, $urandom, 16'($urandom), 16'($urandom), pa, pp);
	endtask

	// random rule: mostly narrow windows so probes both hit and miss
	task automatic random_add();
		logic [31:0] sa, ea;
		logic [15:0] sp, ep;
		sa = $urandom;
		ea = ($urandom_range(0, 9) == 0) ? $urandom : sa + $urandom_range(0, 4000);
		sp = 16'($urandom);
		ep = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(sp + $urandom_range(0, 300));
		send_add(sa, ea, sp, ep);
	endtask

	task automatic random_item();
		int r, k;
		r = $urandom_range(0, 99);
		k = (pool_sa.size() > 0) ? $urandom_range(0, pool_sa.size() - 1) : 0;
		if (r < 30 || pool_sa.size() == 0)
			random_add();
		else if (r < 45)
			send_request(REQ_DEL, pool_sa[k], pool_ea[k], pool_sp[k], pool_ep[k],
				$urandom, 16'($urandom));
		else if (r < 50)
			send_request(REQ_DEL, $urandom, $urandom, 16'($urandom), 16'($urandom),
				$urandom, 16'($urandom));
		else if (r < 85)
			send_check(pool_sa[k] + $urandom_range(0, 8),
				16'(pool_sp[k] + $urandom_range(0, 8)));
		else if (r < 97)
			send_check($urandom, 16'($urandom));
		else
			send_request(REQ_UNK, $urandom, $urandom, 16'($urandom), 16'($urandom),
				$urandom, 16'($urandom));
	endtask

	// stimulus
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty table, extremes, invalid ports, unknown type
		send_check(32'hFFFF_FFFF, 16'hFFFF);
		send_request(REQ_DEL, 0, 0, 0, 0, 0, 0);
		send_add(0, 32'hFFFF_FFFF, 0, 16'hFFFF);
		send_add(32'h10, 32'h20, 16'd5, 16'd4);
		send_add(32'h30, 32'h20, 16'd1, 16'd9);
		send_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		send_check(32'h25, 16'd3);
		send_check(0, 0);
		send_check(32'hFFFF_FFFF, 16'hFFFF);
		send_request(REQ_UNK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF, 16'hFFFF);
		send_request(REQ_DEL, 0, 32'hFFFF_FFFF, 0, 16'hFFFF, 0, 0);
		send_check(32'h25, 16'd3);
		// saturate one rule's hit count
		send_add(32'hAAAA_0000, 32'hAAAA_0000, 16'd80, 16'd80);
		for (int i = 0; i < 131; i++)
			send_check(32'hAAAA_0000, 16'd80);
		// fill the table then overflow it
		while (sb.lo_a.size() < RULE_DEPTH)
			random_add();
		send_add(1, 2, 3, 4);
		send_add(1, 2, 4, 3);
		// drain: sender waits for every response
		in_valid <= 0;
		while (sb.want_status.size() != 0) @(posedge clk);
		// empty the table again by deleting shadow table entries from the front
		while (sb.lo_a.size() > 0)
			send_request(REQ_DEL, sb.lo_a[0], sb.hi_a[0], sb.lo_p[0], sb.hi_p[0], 0, 0);
		pool_sa.delete(); pool_ea.delete(); pool_sp.delete(); pool_ep.delete();
		for (int i = 0; i < 1200; i++) begin
			if (i == 1050) quiet_tail = 1;
			random_item();
		end
		in_valid <= 0;
		send_done = 1;
	end

	// response side with random stalls
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 18);
				out_ready <= 0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
		end
	end

	// sample responses
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(status, rule_slot, hit_total);

	// end of run
	initial begin
		wait (send_done);
		while (sb.want_status.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.want_status.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// timeout
	initial begin
		#40ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
